// File: src/wdfs_pkg.sv
// Shared types and constants for the wire delay filler scheduler.
package wdfs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_CLASS,
    ST_DIV,
    ST_GAP,
    ST_TAIL,
    ST_IMUL,
    ST_IACC,
    ST_DONE
  } state_t;

  localparam logic [1:0] V_SEND = 2'd0;
  localparam logic [1:0] V_FILL = 2'd1;
  localparam logic [1:0] V_DROP = 2'd2;
  localparam logic [1:0] V_IDLE = 2'd3;

  localparam logic [2:0] REG_NS_PER_BYTE = 3'd0;
  localparam logic [2:0] REG_START_TIME  = 3'd1;
  localparam logic [2:0] REG_EXTRA_DELAY = 3'd2;
  localparam logic [2:0] REG_IDLE_LEN    = 3'd3;
  localparam logic [2:0] REG_IDLE_COUNT  = 3'd4;

  localparam logic [23:0] NPB_RESET        = 24'd83886;
  localparam logic [13:0] IDLE_LEN_RESET   = 14'd9000;
  localparam logic [7:0]  IDLE_COUNT_RESET = 8'd128;

  localparam logic [13:0] WIRE_OVERHEAD = 14'd24;
  localparam logic [31:0] MIN_GAP       = 32'd88;
  localparam logic [13:0] BULK_WIRE     = 14'd9000;
  localparam logic [13:0] BULK_FRAME    = 14'd8976;
  localparam logic [31:0] SPLIT_LIMIT   = 32'd15000;
  localparam logic [31:0] CEIL_BIAS     = 32'd6001;
  localparam logic [63:0] DROP_LIMIT    = 64'd10000;
  localparam logic [31:0] GAP_SAT       = 32'hFFFF_FFFF;
  localparam logic [3:0]  DIV_LAST      = 4'd15;
  localparam logic [3:0]  MUL_LAST      = 4'd4;

endpackage

// File: src/wire_delay_filler_scheduler.sv
// Top level of the wire delay filler scheduler: sequencer, shared multiplier and divider.
//
// Input channel: in_valid/in_stall with kind, arrival_ns, pkt_len. A transfer
// happens when in_valid is high and in_stall is low. Output channel:
// out_valid/out_stall with verdict, bulk_count, bulk_len, tail_first_len,
// tail_second_len, new_offset; one result per input item, in order.
// Configuration goes through the APB port, 64-bit data, register i at 8*i.
// One item at a time. A packet uses the shared 16x24 multiplier for four
// offset slices plus drain, then wire time and classification, then the
// shared radix-4 divider for the gap, and the divider once more when the
// gap needs bulk fillers (the divider then divides by 9000).
// A late or dropped packet skips the divider, and when the gap saturates
// the first division is skipped.
// The next item is taken in the cycle after the previous result enters the
// output register at the earliest.
// in_stall is high from a transfer until the result moves to the output
// register, which holds it while out_stall is high; the next item may be taken
// while a result waits, and its result waits in turn until the register frees.
// Reset clears the byte offset, the output valid and loads register defaults.
module wire_delay_filler_scheduler import wdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] arrival_ns,
  input  logic [13:0] pkt_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [18:0] bulk_count,
  output logic [13:0] bulk_len,
  output logic [13:0] tail_first_len,
  output logic [13:0] tail_second_len,
  output logic [63:0] new_offset
);

  logic [23:0] ns_per_byte_q20;
  logic [63:0] start_time_ns;
  logic [39:0] extra_delay_ns;
  logic [13:0] idle_frame_len;
  logic [7:0]  idle_frame_count;
  logic [63:0] byte_offset;

  state_t      state, state_next;
  logic [3:0]  cnt;
  logic [63:0] arrival;
  logic [13:0] plen;
  logic [39:0] prod;
  logic [87:0] acc;
  logic [63:0] diff;
  logic [31:0] gap;
  logic [23:0] rem;
  logic [31:0] quo;
  logic [23:0] den;
  logic        div_bulk;
  logic [13:0] rr;
  logic [1:0]  w_verdict;
  logic [18:0] w_bulk;
  logic [13:0] w_blen;
  logic [13:0] w_t1;
  logic [13:0] w_t2;
  logic [63:0] w_off;

  logic        cfg_wr;
  logic [15:0] mul_a;
  logic [23:0] mul_b;
  logic [24:0] r2a, r2b;
  logic        ge_a, ge_b;
  logic [23:0] ra, rb;
  logic [31:0] quo_next;
  logic [63:0] wire_ns;
  logic        gap_sat;
  logic        load_out;
  logic [63:0] off_pkt;
  logic [12:0] rr_half;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_per_byte_q20  <= NPB_RESET;
      start_time_ns    <= '0;
      extra_delay_ns   <= '0;
      idle_frame_len   <= IDLE_LEN_RESET;
      idle_frame_count <= IDLE_COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_NS_PER_BYTE: ns_per_byte_q20  <= pwdata[23:0];
        REG_START_TIME:  start_time_ns    <= pwdata;
        REG_EXTRA_DELAY: extra_delay_ns   <= pwdata[39:0];
        REG_IDLE_LEN:    idle_frame_len   <= pwdata[13:0];
        REG_IDLE_COUNT:  idle_frame_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_NS_PER_BYTE: prdata = {40'b0, ns_per_byte_q20};
      REG_START_TIME:  prdata = start_time_ns;
      REG_EXTRA_DELAY: prdata = {24'b0, extra_delay_ns};
      REG_IDLE_LEN:    prdata = {50'b0, idle_frame_len};
      REG_IDLE_COUNT:  prdata = {56'b0, idle_frame_count};
      default:         prdata = '0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    if (state == ST_IMUL) begin
      mul_a = {8'b0, idle_frame_count};
      mul_b = {9'b0, {1'b0, idle_frame_len} + {1'b0, WIRE_OVERHEAD}};
    end else begin
      unique case (cnt[1:0])
        2'd0:    mul_a = byte_offset[63:48];
        2'd1:    mul_a = byte_offset[47:32];
        2'd2:    mul_a = byte_offset[31:16];
        default: mul_a = byte_offset[15:0];
      endcase
      mul_b = ns_per_byte_q20;
    end
  end

  // shared divider, two quotient bits per cycle
  always_comb begin
    r2a      = {rem, quo[31]};
    ge_a     = r2a >= {1'b0, den};
    ra       = ge_a ? 24'(r2a - {1'b0, den}) : r2a[23:0];
    r2b      = {ra, quo[30]};
    ge_b     = r2b >= {1'b0, den};
    rb       = ge_b ? 24'(r2b - {1'b0, den}) : r2b[23:0];
    quo_next = {quo[29:0], ge_a, ge_b};
  end

  assign wire_ns = start_time_ns + acc[83:20];
  assign gap_sat = (diff[63:40] != '0) || (diff[39:0] >= {4'b0, ns_per_byte_q20, 12'b0});
  assign off_pkt = byte_offset + {50'b0, plen} + {50'b0, WIRE_OVERHEAD};
  assign rr_half = rr[13:1];
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = kind ? ST_IMUL : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_CLASS;
      ST_CLASS: begin
        if (diff[63]) begin
          state_next = ST_DONE;
        end else if (gap_sat) begin
          state_next = ST_GAP;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = div_bulk ? ST_TAIL : ST_GAP;
        end
      end
      ST_GAP: begin
        if (gap < MIN_GAP) begin
          state_next = ST_DONE;
        end else if (gap > SPLIT_LIMIT) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: state_next = ST_DONE;
      ST_IMUL: state_next = ST_IACC;
      ST_IACC: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        cnt       <= '0;
        acc       <= '0;
        arrival   <= arrival_ns;
        plen      <= pkt_len;
        w_verdict <= V_SEND;
        w_bulk    <= '0;
        w_blen    <= '0;
        w_t1      <= '0;
        w_t2      <= '0;
      end
      ST_MUL: begin
        cnt <= cnt + 4'd1;
        if (cnt != '0) begin
          acc <= {acc[71:0], 16'b0} + {48'b0, prod};
        end
      end
      ST_DIFF: begin
        diff <= arrival + {24'b0, extra_delay_ns} - wire_ns;
      end
      ST_CLASS: begin
        cnt      <= '0;
        den      <= ns_per_byte_q20;
        rem      <= diff[35:12];
        quo      <= {diff[11:0], 20'b0};
        div_bulk <= 1'b0;
        gap      <= GAP_SAT;
        if (diff[63]) begin
          if ($signed(diff) < -$signed(DROP_LIMIT)) begin
            w_verdict <= V_DROP;
            w_off     <= byte_offset;
          end else begin
            w_verdict <= V_SEND;
            w_off     <= off_pkt;
          end
        end
      end
      ST_DIV: begin
        cnt <= cnt + 4'd1;
        rem <= rb;
        quo <= quo_next;
        if (cnt == DIV_LAST) begin
          if (div_bulk) begin
            w_bulk <= quo_next[18:0];
            w_blen <= BULK_FRAME;
            rr     <= 14'({8'b0, rb} + CEIL_BIAS);
          end else begin
            gap <= quo_next;
          end
        end
      end
      ST_GAP: begin
        cnt      <= '0;
        den      <= {10'b0, BULK_WIRE};
        rem      <= '0;
        quo      <= gap - CEIL_BIAS;
        div_bulk <= 1'b1;
        rr       <= gap[13:0];
        if (gap < MIN_GAP) begin
          w_verdict <= V_SEND;
          w_off     <= off_pkt;
        end else begin
          w_verdict <= V_FILL;
          w_off     <= off_pkt + {32'b0, gap};
        end
      end
      ST_TAIL: begin
        if (rr <= BULK_WIRE) begin
          w_t1 <= rr - WIRE_OVERHEAD;
          w_t2 <= '0;
        end else begin
          w_t1 <= {1'b0, rr_half} - WIRE_OVERHEAD;
          w_t2 <= {1'b0, rr_half} + {13'b0, rr[0]} - WIRE_OVERHEAD;
        end
      end
      ST_IMUL: ;
      ST_IACC: begin
        w_verdict <= V_IDLE;
        w_bulk    <= {11'b0, idle_frame_count};
        w_blen    <= idle_frame_len;
        w_off     <= byte_offset + {24'b0, prod};
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      out_valid   <= 1'b0;
    end else if (load_out) begin
      byte_offset <= w_off;
      out_valid   <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict         <= w_verdict;
      bulk_count      <= w_bulk;
      bulk_len        <= w_blen;
      tail_first_len  <= w_t1;
      tail_second_len <= w_t2;
      new_offset      <= w_off;
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < den)
    else $error("divider remainder out of range");

  a_send_no_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == V_SEND || verdict == V_DROP) |->
      bulk_count == '0 && tail_first_len == '0 && tail_second_len == '0)
    else $error("filler fields set on unfilled verdict");

  a_offset_tracks_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_offset == byte_offset)
    else $error("byte offset differs from reported offset");

endmodule
